// ----- src/bounded_ordered_value_list_defines.svh -----
// Assertion helpers used by the list RTL
`ifndef BOUNDED_ORDERED_VALUE_LIST_DEFINES_SVH
`define BOUNDED_ORDERED_VALUE_LIST_DEFINES_SVH

// checked only outside reset
`define BOVL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BOVL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/bovl_pkg.sv -----
package bovl_pkg;

    localparam int W_OP     = 3;
    localparam int W_VALUE  = 32;
    localparam int W_STATUS = 2;
    localparam int W_POS    = 4;
    localparam int W_COUNT  = 5;

    localparam logic [W_OP-1:0] OP_APPEND = 3'd0;
    localparam logic [W_OP-1:0] OP_DELETE = 3'd1;
    localparam logic [W_OP-1:0] OP_CUT    = 3'd2;
    localparam logic [W_OP-1:0] OP_SEARCH = 3'd3;
    localparam logic [W_OP-1:0] OP_CLEAR  = 3'd4;

    localparam logic [W_STATUS-1:0] ST_OK      = 2'd0;
    localparam logic [W_STATUS-1:0] ST_FULL    = 2'd1;
    localparam logic [W_STATUS-1:0] ST_EMPTY   = 2'd2;
    localparam logic [W_STATUS-1:0] ST_MISSING = 2'd3;

    localparam logic [W_POS-1:0]   POS_MAX   = 4'd15;
    localparam logic [W_COUNT-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // search token walking down the chain
    typedef struct packed {
        logic valid;
        logic found;
    } t_tok;

    // broadcast strobes from the controller to every cell
    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- src/bovl_cell.sv -----
module bovl_cell
    import bovl_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_wr_idx,
    input  logic [W_VALUE-1:0] i_wr_data,
    input  logic [W_VALUE-1:0] i_probe,
    input  logic [CNT_W-1:0]   i_count,
    input  t_tok               i_tok,
    input  logic [IDX_W-1:0]   i_tok_pos,
    input  logic [W_VALUE-1:0] i_next_entry,
    output t_tok               o_tok,
    output logic [IDX_W-1:0]   o_tok_pos,
    output logic [W_VALUE-1:0] o_entry
);

    logic [W_VALUE-1:0] r_entry;
    logic               r_tail;
    t_tok               r_tok;
    logic [IDX_W-1:0]   r_tok_pos;

    logic w_live;
    logic w_match;
    logic w_hit_here;

    assign w_live     = CNT_W'(IDX) < i_count;
    assign w_match    = w_live && (r_entry == i_probe);
    assign w_hit_here = !i_tok.found && w_match;

    // entry: append write or move up one place on delete
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_wr_idx == IDX_W'(IDX))) begin
            r_entry <= i_wr_data;
        end else if (i_ctl.shift && r_tail) begin
            r_entry <= i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_tail <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_tok.found <= i_tok.found || w_match;
            // tail: this cell sits at or after the first match
            if (i_tok.valid) begin
                r_tail <= i_tok.found || w_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_pos <= w_hit_here ? IDX_W'(IDX) : i_tok_pos;
    end

    assign o_tok     = r_tok;
    assign o_tok_pos = r_tok_pos;
    assign o_entry   = r_entry;

endmodule

// ----- src/bounded_ordered_value_list.sv -----
// Ordered list of up to CAPACITY 32-bit words, kept packed from the head.
// Input channel (i_valid/o_ready) takes one beat of operation and value:
// append, delete first match, cut from first match, search, clear.
// Output channel (o_valid/i_ready) returns one beat per input beat:
// status, position of the first match (search only) and the new count.
// Items are handled one at a time; o_ready is high only while idle.
// Append, clear, unused codes and any operation on an empty list:
//   no scan; the result is registered on acceptance and then loaded into the output register.
// Delete, cut and search on a non-empty list send a search token down
// the row of CAPACITY cells, one cell per cycle, and the result is
// settled when the token leaves the last cell.
// Delete moves every entry after the match up one place, all in the same cycle.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result waits in the output register; one more item may be
// taken and its result held inside, and no further item is taken until
// the output register frees.
`include "bounded_ordered_value_list_defines.svh"

module bounded_ordered_value_list
    import bovl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [W_OP-1:0]     i_operation,
    input  logic [W_VALUE-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [W_STATUS-1:0] o_status,
    output logic [W_POS-1:0]    o_position,
    output logic [W_COUNT-1:0]  o_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]    r_count;
    logic [W_OP-1:0]     r_op;
    logic [W_VALUE-1:0]  r_value;
    logic                r_inject;
    logic [W_STATUS-1:0] r_status;
    logic [W_POS-1:0]    r_pos;
    logic                r_out_valid;
    logic [W_STATUS-1:0] r_out_status;
    logic [W_POS-1:0]    r_out_pos;
    logic [W_COUNT-1:0]  r_out_count;

    logic      w_accept;
    logic      w_scan_op;
    logic      w_full;
    logic      w_load;
    t_cell_ctl w_ctl;

    t_tok               w_tok     [CAPACITY+1];
    logic [IDX_W-1:0]   w_tok_pos [CAPACITY+1];
    logic [W_VALUE-1:0] w_entry   [CAPACITY];

    assign w_accept  = i_valid && o_ready;
    assign w_full    = r_count >= CNT_W'(CAPACITY);
    assign w_scan_op = (r_count != '0) &&
                       ((i_operation == OP_DELETE) || (i_operation == OP_CUT) ||
                        (i_operation == OP_SEARCH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = w_scan_op ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (w_tok[CAPACITY].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_ctl.wr    = w_accept && (i_operation == OP_APPEND) && !w_full;
    assign w_ctl.shift = w_tok[CAPACITY].valid && w_tok[CAPACITY].found &&
                         (r_op == OP_DELETE);

    assign w_tok[0]     = '{valid: r_inject, found: 1'b0};
    assign w_tok_pos[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_row
        logic [W_VALUE-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        bovl_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_wr_idx     (r_count[IDX_W-1:0]),
            .i_wr_data    (i_value),
            .i_probe      (r_value),
            .i_count      (r_count),
            .i_tok        (w_tok[g]),
            .i_tok_pos    (w_tok_pos[g]),
            .i_next_entry (w_next),
            .o_tok        (w_tok[g+1]),
            .o_tok_pos    (w_tok_pos[g+1]),
            .o_entry      (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_inject <= 1'b0;
        end else begin
            r_inject <= w_accept && w_scan_op;
            if (w_accept) begin
                case (i_operation)
                    OP_APPEND: begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        r_count <= '0;
                    end
                    default: begin
                        r_count <= r_count;
                    end
                endcase
            end else if (w_tok[CAPACITY].valid && w_tok[CAPACITY].found) begin
                case (r_op)
                    OP_DELETE: r_count <= r_count - 1'b1;
                    OP_CUT:    r_count <= CNT_W'(w_tok_pos[CAPACITY]);
                    default:   r_count <= r_count;
                endcase
            end
        end
    end

    // per-item result, settled before the output register takes it
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_value <= i_value;
            r_pos   <= '0;
            case (i_operation)
                OP_APPEND: r_status <= w_full ? ST_FULL : ST_OK;
                OP_DELETE,
                OP_CUT,
                OP_SEARCH,
                OP_CLEAR:  r_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                default:   r_status <= ST_OK;
            endcase
        end else if (w_tok[CAPACITY].valid) begin
            if (!w_tok[CAPACITY].found) begin
                r_status <= ST_MISSING;
            end else if (r_op == OP_SEARCH) begin
                r_pos <= (32'(w_tok_pos[CAPACITY]) > 32'(POS_MAX)) ?
                         POS_MAX : W_POS'(w_tok_pos[CAPACITY]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_pos    <= r_pos;
            r_out_count  <= (32'(r_count) > 32'(COUNT_MAX)) ?
                            COUNT_MAX : W_COUNT'(r_count);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_position = r_out_pos;
    assign o_count    = r_out_count;

    `BOVL_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `BOVL_ASSERT(a_tok_in_scan, w_tok[CAPACITY].valid |-> r_state == S_SCAN, "stray token")
    `BOVL_ASSERT(a_append_grows, w_ctl.wr |=> r_count == $past(r_count) + 1'b1, "append lost")
    `BOVL_ASSERT(a_count_quiet, !w_accept && !w_tok[CAPACITY].valid |=> $stable(r_count), "count drift")
    `BOVL_ASSERT(a_shift_found, w_ctl.shift |-> r_count != '0, "shift on empty list")

endmodule
